// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define HLCC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// concurrent assertion on the block clock and reset
`define HLCC_ASSERT(lbl, prop, msg) \
  `HLCC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/hlcc_pkg.sv =====
// types and constants of the hsv light color classifier
`timescale 1ns / 1ps
`default_nettype none

package hlcc_pkg;

  // channel field widths
  localparam int unsigned CH_W    = 8;
  localparam int unsigned TOTAL_W = 17;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned CONF_W  = 4;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;
  localparam logic [CONF_W-1:0]  STREAK_MAX = '1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_FRACTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_CONFIRM = 2'd2;

  localparam logic              TEST_MODE_RST     = 1'b0;
  localparam logic [FRAC_W-1:0] AREA_FRACTION_RST = 16'd7009;
  localparam logic [CONF_W-1:0] GREEN_CONFIRM_RST = 4'd3;

  // reciprocal scales of the hsv conversion
  localparam int unsigned SatScale = 1044480;
  localparam int unsigned HueScale = 122880;
  localparam int unsigned SD_W     = 20;
  localparam int unsigned HD_W     = 17;

  // color windows on h, s and v
  localparam logic [7:0] RED_HUE_LOW_MAX  = 8'd10;
  localparam logic [7:0] RED_HUE_HIGH_MIN = 8'd170;
  localparam logic [7:0] RED_HUE_HIGH_MAX = 8'd180;
  localparam logic [8:0] RED_SAT_MIN      = 9'd70;
  localparam logic [7:0] RED_VAL_MIN      = 8'd50;
  localparam logic [7:0] GRN_HUE_MIN      = 8'd42;
  localparam logic [7:0] GRN_HUE_MAX      = 8'd170;
  localparam logic [8:0] GRN_SAT_MIN      = 9'd25;
  localparam logic [7:0] GRN_VAL_MIN      = 8'd166;

  // queue between front and back
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    LIGHT_NONE  = 2'd0,
    LIGHT_RED   = 2'd1,
    LIGHT_GREEN = 2'd2
  } light_e;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic            last_pixel;
  } pixel_t;

  typedef struct packed {
    light_e             light_state;
    logic               start_request;
    logic               shutdown_request;
    logic [TOTAL_W-1:0] red_total;
    logic [TOTAL_W-1:0] green_total;
  } result_t;

  // per-pixel classification handed to the back part
  typedef struct packed {
    logic is_red;
    logic is_green;
    logic last_pixel;
  } flags_t;

  typedef struct packed {
    logic              valid;
    logic [QCNT_W-1:0] free;
  } queue_stat_t;

  typedef struct packed {
    logic              test_mode;
    logic [FRAC_W-1:0] area_fraction_q16;
    logic [CONF_W-1:0] green_confirm_frames;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/hlcc_stream_if.sv =====
// valid/ready stream channel with a typed payload
`timescale 1ns / 1ps
`default_nettype none

interface hlcc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hlcc_front.sv =====
// front part: bgr to hsv pipeline and per-pixel color flags
`timescale 1ns / 1ps
`default_nettype none

module hlcc_front import hlcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hlcc_stream_if.sink pix,
  input  queue_stat_t q_stat_i,
  output logic        push_o,
  output flags_t      push_data_o
);

  // reciprocal tables, entry zero read as zero
  logic [SD_W-1:0] sd_tab [256];
  logic [HD_W-1:0] hd_tab [256];

  for (genvar i = 0; i < 256; i++) begin : g_tab
    if (i == 0) begin : g_zero
      assign sd_tab[i] = '0;
      assign hd_tab[i] = '0;
    end else begin : g_val
      localparam int unsigned SdVal = (2 * SatScale + i) / (2 * i);
      localparam int unsigned HdVal = (2 * HueScale + i) / (2 * i);
      assign sd_tab[i] = SD_W'(SdVal);
      assign hd_tab[i] = HD_W'(HdVal);
    end
  end

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic [2:0] inflight;
  logic       accept;

  // admit a pixel only if the queue has room for everything in flight
  assign inflight  = 3'(s1_valid_q) + 3'(s2_valid_q) + 3'(s3_valid_q) + 3'(s4_valid_q);
  assign pix.ready = QCNT_W'(inflight) < q_stat_i.free;
  assign accept    = pix.valid && pix.ready;

  // stage 1: max, min and hue numerator
  logic [7:0] b, g, r, mx_d, mn_d, diff_d;
  logic signed [11:0] sb, sg, sr, sdiff, num_d;

  always_comb begin
    b = pix.data.blue;
    g = pix.data.green;
    r = pix.data.red;
    mx_d = b;
    mn_d = b;
    if (g > mx_d) mx_d = g;
    if (r > mx_d) mx_d = r;
    if (g < mn_d) mn_d = g;
    if (r < mn_d) mn_d = r;
    diff_d = mx_d - mn_d;
    sb    = $signed({4'b0, b});
    sg    = $signed({4'b0, g});
    sr    = $signed({4'b0, r});
    sdiff = $signed({4'b0, diff_d});
    if (mx_d == r) begin
      num_d = sg - sb;
    end else if (mx_d == g) begin
      num_d = sb - sr + (sdiff <<< 1);
    end else begin
      num_d = sr - sg + (sdiff <<< 2);
    end
  end

  logic [7:0]         s1_mx_q, s1_diff_q;
  logic signed [11:0] s1_num_q;
  logic               s1_last_q;

  logic [7:0]         s2_mx_q, s2_diff_q;
  logic signed [11:0] s2_num_q;
  logic [SD_W-1:0]    s2_sd_q;
  logic [HD_W-1:0]    s2_hd_q;
  logic               s2_last_q;

  logic [27:0]        s3_sat_prod_q;
  logic signed [29:0] s3_hue_prod_q;
  logic [7:0]         s3_mx_q;
  logic               s3_last_q;

  flags_t             s4_flags_q;

  // stage 4 logic: rounding, hue wrap and color windows
  logic [20:0]        sat_rnd;
  logic [8:0]         sat;
  logic signed [29:0] hue_rnd;
  logic signed [8:0]  hue9;
  logic [8:0]         hue_wrap;
  logic [7:0]         hue;
  flags_t             flags_d;

  always_comb begin
    sat_rnd  = 21'(s3_sat_prod_q) + 21'd2048;
    sat      = sat_rnd[20:12];
    hue_rnd  = s3_hue_prod_q + 30'sd2048;
    hue9     = $signed(hue_rnd[20:12]);
    hue_wrap = hue9[8] ? 9'($unsigned(hue9) + 9'd180) : $unsigned(hue9);
    hue      = hue_wrap[7:0];
    flags_d.is_red = ((hue <= RED_HUE_LOW_MAX) ||
                      (hue inside {[RED_HUE_HIGH_MIN:RED_HUE_HIGH_MAX]})) &&
                     (sat >= RED_SAT_MIN) && (s3_mx_q >= RED_VAL_MIN);
    flags_d.is_green = (hue inside {[GRN_HUE_MIN:GRN_HUE_MAX]}) &&
                       (sat >= GRN_SAT_MIN) && (s3_mx_q >= GRN_VAL_MIN);
    flags_d.last_pixel = s3_last_q;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // stage payloads, table lookups and multiplies
  always_ff @(posedge clk_i) begin
    s1_mx_q   <= mx_d;
    s1_diff_q <= diff_d;
    s1_num_q  <= num_d;
    s1_last_q <= pix.data.last_pixel;

    s2_mx_q   <= s1_mx_q;
    s2_diff_q <= s1_diff_q;
    s2_num_q  <= s1_num_q;
    s2_sd_q   <= sd_tab[s1_mx_q];
    s2_hd_q   <= hd_tab[s1_diff_q];
    s2_last_q <= s1_last_q;

    s3_sat_prod_q <= 28'(s2_diff_q) * 28'(s2_sd_q);
    s3_hue_prod_q <= 30'(s2_num_q) * 30'($signed({1'b0, s2_hd_q}));
    s3_mx_q       <= s2_mx_q;
    s3_last_q     <= s2_last_q;

    s4_flags_q <= flags_d;
  end

  assign push_o      = s4_valid_q;
  assign push_data_o = s4_flags_q;

endmodule

`default_nettype wire

// ===== rtl/core/hlcc_queue.sv =====
// short fifo of pixel flags between front and back
`timescale 1ns / 1ps
`default_nettype none

module hlcc_queue import hlcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  flags_t      push_data_i,
  input  logic        pop_i,
  output flags_t      head_o,
  output queue_stat_t stat_o
);

  flags_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.valid = count_q != '0;
  assign stat_o.free  = QCNT_W'(QDEPTH) - count_q;

endmodule

`default_nettype wire

// ===== rtl/core/hlcc_back.sv =====
// back part: frame counters, threshold, classification and streak
`timescale 1ns / 1ps
`default_nettype none

module hlcc_back import hlcc_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  queue_stat_t   q_stat_i,
  input  flags_t        head_i,
  output logic          pop_o,
  hlcc_stream_if.source res
);

  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned PROD_W = CNT_W + FRAC_W;
  localparam int unsigned EXT_W  = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_THRESH,
    ST_CLASSIFY
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   pix_cnt_q, red_cnt_q, grn_cnt_q, thr_q;
  logic [CONF_W-1:0]  streak_q;
  logic               out_valid_q;
  result_t            out_q;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c < CNT_W'(MAX_PIXELS)) ? c + CNT_W'(1) : c;
  endfunction

  function automatic logic [TOTAL_W-1:0] clip_total(input logic [CNT_W-1:0] c);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(c);
    return (ext > EXT_W'(TOTAL_MAX)) ? TOTAL_MAX : ext[TOTAL_W-1:0];
  endfunction

  // a frame end waits until the previous result has been taken
  assign pop_o = (state_q == ST_ACCUM) && q_stat_i.valid &&
                 !(head_i.last_pixel && out_valid_q);

  // threshold product
  logic [PROD_W-1:0] thr_prod;
  assign thr_prod = PROD_W'(pix_cnt_q) * PROD_W'(cfg_i.area_fraction_q16);

  // frame decision
  logic              frame_green, frame_red, start;
  logic [CONF_W-1:0] streak_inc;

  always_comb begin
    frame_green = (red_cnt_q < thr_q) && (grn_cnt_q > thr_q);
    frame_red   = (red_cnt_q > thr_q) && (grn_cnt_q < thr_q);
    streak_inc  = (streak_q == STREAK_MAX) ? streak_q : streak_q + CONF_W'(1);
    start       = frame_green && (streak_inc > cfg_i.green_confirm_frames);
  end

  // sequencer, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      pix_cnt_q   <= '0;
      red_cnt_q   <= '0;
      grn_cnt_q   <= '0;
      thr_q       <= '0;
      streak_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && res.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_ACCUM: begin
          if (pop_o) begin
            pix_cnt_q <= sat_inc(pix_cnt_q);
            if (head_i.is_red)   red_cnt_q <= sat_inc(red_cnt_q);
            if (head_i.is_green) grn_cnt_q <= sat_inc(grn_cnt_q);
            if (head_i.last_pixel) state_q <= ST_THRESH;
          end
        end
        ST_THRESH: begin
          thr_q   <= thr_prod[PROD_W-1:FRAC_W];
          state_q <= ST_CLASSIFY;
        end
        ST_CLASSIFY: begin
          if (frame_green) begin
            out_q.light_state <= LIGHT_GREEN;
            streak_q          <= streak_inc;
          end else if (frame_red) begin
            out_q.light_state <= LIGHT_RED;
            streak_q          <= '0;
          end else begin
            out_q.light_state <= LIGHT_NONE;
          end
          out_q.start_request    <= start;
          out_q.shutdown_request <= start && !cfg_i.test_mode;
          out_q.red_total        <= clip_total(red_cnt_q);
          out_q.green_total      <= clip_total(grn_cnt_q);
          out_valid_q            <= 1'b1;
          pix_cnt_q              <= '0;
          red_cnt_q              <= '0;
          grn_cnt_q              <= '0;
          state_q                <= ST_ACCUM;
        end
        default: begin
          state_q <= ST_ACCUM;
        end
      endcase
    end
  end

  assign res.valid = out_valid_q;
  assign res.data  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/hsv_light_color_classifier_core.sv =====
// top level of the hsv light color classifier
// a last pixel's frame result is registered after the hsv pipeline, the queue and
// the back part's threshold multiply and decision states, where no pixel is popped
// throughput: one pixel per cycle through the hsv pipeline and the frame counters
// while the queue has room; a frame end waits until the previous result is taken
// reset (async, active low) clears counters, streak, queue and sets config defaults
`timescale 1ns / 1ps
`default_nettype none

module hsv_light_color_classifier_core import hlcc_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  hlcc_stream_if.sink           pixel_i,
  hlcc_stream_if.source         result_o
);

  cfg_t        cfg_q;
  queue_stat_t q_stat;
  flags_t      push_data, head;
  logic        push, pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.test_mode            <= TEST_MODE_RST;
      cfg_q.area_fraction_q16    <= AREA_FRACTION_RST;
      cfg_q.green_confirm_frames <= GREEN_CONFIRM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEST_MODE:     cfg_q.test_mode            <= cfg_wdata_i[0];
        CFG_AREA_FRACTION: cfg_q.area_fraction_q16    <= cfg_wdata_i[FRAC_W-1:0];
        CFG_GREEN_CONFIRM: cfg_q.green_confirm_frames <= cfg_wdata_i[CONF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hlcc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix         (pixel_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  hlcc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  hlcc_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_stat_i (q_stat),
    .head_i   (head),
    .pop_o    (pop),
    .res      (result_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/hlcc_checker.sv =====
// port-level checker of the classifier result channel, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hlcc_checker import hlcc_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    res_valid_i,
  input logic    res_ready_i,
  input result_t res_data_i
);

  // a stalled result holds
  `HLCC_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i), "result changed while stalled")

  // shutdown only with start
  `HLCC_ASSERT(a_shut_start, res_valid_i && res_data_i.shutdown_request |-> res_data_i.start_request, "shutdown without start")

  // start only on a green frame
  `HLCC_ASSERT(a_start_green, res_valid_i && res_data_i.start_request |-> res_data_i.light_state == LIGHT_GREEN, "start on non-green frame")

  // red frame has at least as many red pixels as green
  `HLCC_ASSERT(a_red_major, res_valid_i && res_data_i.light_state == LIGHT_RED |-> res_data_i.red_total >= res_data_i.green_total, "red frame with green majority")

  // green frame has at least as many green pixels as red
  `HLCC_ASSERT(a_green_major, res_valid_i && res_data_i.light_state == LIGHT_GREEN |-> res_data_i.green_total >= res_data_i.red_total, "green frame with red majority")

endmodule

bind hsv_light_color_classifier_core hlcc_checker u_hlcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .res_data_i  (result_o.data)
);

`default_nettype wire

// ===== tb/hsv_light_color_classifier_core_test.sv =====
// testbench of the hsv light color classifier core: frame prediction and result checking
`timescale 1ns / 1ps

module hsv_light_color_classifier_core_test;
  import hlcc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int MAX_PIXELS     = 65536;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 20;
  localparam int IDLE_LIMIT     = 4000;
  localparam int PURE_FRAME_LEN = 20;

  typedef enum {PIX_ANY, PIX_RED, PIX_GREEN, PIX_DUAL} pixel_kind_e;
  typedef enum {
    THEME_NOISE, THEME_MIXED, THEME_RED, THEME_GREEN,
    THEME_PURE_RED, THEME_PURE_GREEN, THEME_PURE_DUAL
  } frame_theme_e;

  // frame counters, streak and register copy; holds the frame results still to come
  class frame_scoreboard;
    logic              test_mode;
    logic [FRAC_W-1:0] area_fraction;
    logic [CONF_W-1:0] confirm_frames;
    logic [CONF_W-1:0] green_streak;
    int unsigned       red_count, green_count, pixel_count;
    result_t           expected_frames[$];
    int                errors;

    function new();
      test_mode      = TEST_MODE_RST;
      area_fraction  = AREA_FRACTION_RST;
      confirm_frames = GREEN_CONFIRM_RST;
      green_streak   = '0;
      red_count      = 0;
      green_count    = 0;
      pixel_count    = 0;
      errors         = 0;
    endfunction

    // register write, values cut to the register width, unknown index dropped
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TEST_MODE:     test_mode = data[0];
        CFG_AREA_FRACTION: area_fraction = data[FRAC_W-1:0];
        CFG_GREEN_CONFIRM: confirm_frames = data[CONF_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned bump(int unsigned c);
      return (c < MAX_PIXELS) ? c + 1 : c;
    endfunction

    // integer hsv with rounded reciprocals, hue in units of two degrees
    function void to_hsv(input int b, g, r, output int h, s, v);
      int mx, mn, diff, num, sd, hd, hue;
      mx = b;
      mn = b;
      if (g > mx) mx = g;
      if (r > mx) mx = r;
      if (g < mn) mn = g;
      if (r < mn) mn = r;
      diff = mx - mn;
      v = mx;
      if (mx > 0) begin
        sd = (2 * int'(SatScale) + mx) / (2 * mx);
        s = (diff * sd + 2048) >>> 12;
      end else begin
        s = 0;
      end
      h = 0;
      if (diff != 0) begin
        if (mx == r) num = g - b;
        else if (mx == g) num = b - r + 2 * diff;
        else num = r - g + 4 * diff;
        hd = (2 * int'(HueScale) + diff) / (2 * diff);
        // arithmetic shift floors negative hues before the wrap
        hue = (num * hd + 2048) >>> 12;
        if (hue < 0) hue += 180;
        h = hue;
      end
    endfunction

    // count one accepted pixel request, close the frame on its last pixel
    function void note_pixel(pixel_t p);
      int h, s, v;
      longint unsigned thr;
      result_t e;
      to_hsv(p.blue, p.green, p.red, h, s, v);
      if (((h >= 0 && h <= 10) || (h >= 170 && h <= 180)) && s >= 70 && v >= 50)
        red_count = bump(red_count);
      if (h >= 42 && h <= 170 && s >= 25 && v >= 166)
        green_count = bump(green_count);
      pixel_count = bump(pixel_count);
      if (!p.last_pixel) return;

      thr = (longint'(pixel_count) * area_fraction) >> 16;
      e = '0;
      if (red_count < thr && green_count > thr) begin
        e.light_state = LIGHT_GREEN;
        if (green_streak < STREAK_MAX) green_streak++;
        if (green_streak > confirm_frames) begin
          e.start_request    = 1'b1;
          e.shutdown_request = !test_mode;
        end
      end else if (red_count > thr && green_count < thr) begin
        e.light_state = LIGHT_RED;
        green_streak  = '0;
      end else begin
        e.light_state = LIGHT_NONE;
      end
      // counts never pass the pixel limit, so they fit the total width as is
      e.red_total   = TOTAL_W'(red_count);
      e.green_total = TOTAL_W'(green_count);
      expected_frames.push_back(e);
      red_count   = 0;
      green_count = 0;
      pixel_count = 0;
    endfunction

    // compare one accepted result with the oldest pending frame
    function void check_result(result_t got);
      result_t want;
      if (expected_frames.size() == 0) begin
        $error("result with no frame pending: %h", got);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      if (got.light_state !== want.light_state) begin
        $error("light_state: expected %0d, actual %0d", want.light_state, got.light_state);
        errors++;
      end
      if (got.start_request !== want.start_request) begin
        $error("start_request: expected %0d, actual %0d",
               want.start_request, got.start_request);
        errors++;
      end
      if (got.shutdown_request !== want.shutdown_request) begin
        $error("shutdown_request: expected %0d, actual %0d",
               want.shutdown_request, got.shutdown_request);
        errors++;
      end
      if (got.red_total !== want.red_total) begin
        $error("red_total: expected %0d, actual %0d", want.red_total, got.red_total);
        errors++;
      end
      if (got.green_total !== want.green_total) begin
        $error("green_total: expected %0d, actual %0d", want.green_total, got.green_total);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    no_idle = 1'b0;
  bit                    hold_pending = 1'b0;
  int                    idle_cycles = 0;
  frame_scoreboard       board = new();

  hlcc_stream_if #(.T(pixel_t))  pixel_ch ();
  hlcc_stream_if #(.T(result_t)) result_ch ();

  hsv_light_color_classifier_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .pixel_i    (pixel_ch),
    .result_o   (result_ch)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // pixel of a given color family
  function automatic pixel_t make_pixel(pixel_kind_e kind, bit last);
    pixel_t p;
    int peak;
    p.last_pixel = last;
    case (kind)
      PIX_RED: begin
        peak    = $urandom_range(60, 255);
        p.red   = 8'(peak);
        p.green = 8'($urandom_range(0, peak / 8));
        p.blue  = 8'($urandom_range(0, peak / 8));
      end
      PIX_GREEN: begin
        peak    = $urandom_range(170, 255);
        p.green = 8'(peak);
        p.red   = 8'($urandom_range(0, peak / 2));
        p.blue  = 8'($urandom_range(0, peak / 2));
      end
      PIX_DUAL: begin
        // hue lands on 170, inside both the red and the green window
        p.blue  = 8'd85;
        p.green = 8'd0;
        p.red   = 8'd255;
      end
      default: begin
        p.blue  = 8'($urandom_range(0, 255));
        p.green = 8'($urandom_range(0, 255));
        p.red   = 8'($urandom_range(0, 255));
      end
    endcase
    return p;
  endfunction

  function automatic pixel_kind_e pick_kind(frame_theme_e theme);
    int roll;
    roll = $urandom_range(0, 99);
    case (theme)
      THEME_PURE_RED:   return PIX_RED;
      THEME_PURE_GREEN: return PIX_GREEN;
      THEME_PURE_DUAL:  return PIX_DUAL;
      THEME_RED:        return (roll < 88) ? PIX_RED : PIX_ANY;
      THEME_GREEN:      return (roll < 88) ? PIX_GREEN : (roll < 96) ? PIX_ANY : PIX_RED;
      THEME_MIXED:      return (roll < 40) ? PIX_GREEN : (roll < 80) ? PIX_RED : PIX_ANY;
      default:          return PIX_ANY;
    endcase
  endfunction

  // offer one pixel request and hold it until taken
  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      pixel_ch.valid <= 1'b0;
    end
    @(negedge clk);
    pixel_ch.valid <= 1'b1;
    pixel_ch.data  <= p;
    do @(posedge clk); while (!pixel_ch.ready);
  endtask

  task automatic send_frame(input frame_theme_e theme, input int len);
    for (int i = 0; i < len; i++) send_pixel(make_pixel(pick_kind(theme), i == len - 1));
  endtask

  // green themes tend to repeat so streaks build up
  task automatic run_frames(input int count, input int lo, input int hi, input bit green_run);
    frame_theme_e theme;
    theme = THEME_NOISE;
    repeat (count) begin
      if (green_run)
        theme = ($urandom_range(0, 11) == 0) ? THEME_NOISE : THEME_PURE_GREEN;
      else if (!(theme == THEME_GREEN && $urandom_range(0, 9) < 7))
        theme = frame_theme_e'($urandom_range(0, 3));
      send_frame(theme, $urandom_range(lo, hi));
    end
  endtask

  // withdraw the last request, then wait for every pending frame result
  task automatic wait_drained();
    @(negedge clk);
    pixel_ch.valid <= 1'b0;
    while (board.expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, data);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] mode, input logic [CFG_DATA_W-1:0] frac,
                           input logic [CFG_DATA_W-1:0] confirm);
    wait_drained();
    write_reg(CFG_TEST_MODE, mode);
    write_reg(CFG_AREA_FRACTION, frac);
    write_reg(CFG_GREEN_CONFIRM, confirm);
  endtask

  // request and result monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (pixel_ch.valid && pixel_ch.ready) board.note_pixel(pixel_ch.data);
      if (result_ch.valid && result_ch.ready) board.check_result(result_ch.data);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("hsv_light_color_classifier_core: mismatch");
      $finish;
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin : receiver
    int stall;
    stall = 0;
    result_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (stall > 0) begin
        result_ch.ready <= 1'b0;
        stall--;
      end else begin
        result_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // stimulus
  initial begin : stimulus
    pixel_t directed[$];
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    pixel_ch.valid = 1'b0;
    pixel_ch.data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // corner colors, gray, hue wrap, the dual-window hue, then one-pixel frames
    directed = '{
      {8'd0,   8'd0,   8'd0,   1'b0},
      {8'd255, 8'd255, 8'd255, 1'b0},
      {8'd255, 8'd0,   8'd0,   1'b0},
      {8'd0,   8'd255, 8'd0,   1'b0},
      {8'd0,   8'd0,   8'd255, 1'b0},
      {8'd85,  8'd0,   8'd255, 1'b0},
      {8'd128, 8'd128, 8'd128, 1'b0},
      {8'd255, 8'd255, 8'd0,   1'b0},
      {8'd0,   8'd255, 8'd255, 1'b0},
      {8'd255, 8'd0,   8'd255, 1'b0},
      {8'd10,  8'd0,   8'd255, 1'b0},
      {8'd0,   8'd10,  8'd255, 1'b0},
      {8'd1,   8'd0,   8'd0,   1'b1},
      {8'd85,  8'd0,   8'd255, 1'b1},
      {8'd0,   8'd0,   8'd0,   1'b1}
    };
    foreach (directed[i]) send_pixel(directed[i]);
    // ten pure green pixels clear the default threshold
    for (int i = 0; i < 10; i++) send_pixel({8'd0, 8'd255, 8'd0, i == 9});

    // default registers
    run_frames(8, 10, 24, 1'b0);
    // zero fraction: no frame can be red or green
    configure(16'd1, 16'd0, 16'd0);
    run_frames(6, 1, 16, 1'b0);
    // full fraction and the highest useful confirm count
    configure(16'd0, 16'hFFFF, 16'd14);
    run_frames(25, 2, 4, 1'b1);
    // upper bits dropped: test mode on, confirm fifteen never starts
    configure(16'h0003, 16'd30000, 16'h00FF);
    run_frames(12, 3, 10, 1'b0);
    // test mode off through masking, a write to the unused index, no idling
    configure(16'hFFFE, 16'd12000, 16'd0);
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    no_idle = 1'b1;
    run_frames(8, 6, 20, 1'b0);
    no_idle = 1'b0;
    // short green frames against a long receiver hold-off
    configure(16'd1, 16'd40000, 16'd0);
    hold_pending = 1'b1;
    no_idle      = 1'b1;
    run_frames(40, 1, 2, 1'b1);
    // long single-color frames, red only and then both windows
    configure(16'd0, AREA_FRACTION_RST, GREEN_CONFIRM_RST);
    send_frame(THEME_PURE_RED, PURE_FRAME_LEN);
    send_frame(THEME_PURE_DUAL, PURE_FRAME_LEN);
    no_idle = 1'b0;
    run_frames(3, 10, 24, 1'b0);
    @(negedge clk);
    pixel_ch.valid <= 1'b0;

    wait_drained();
    if (board.errors == 0)
      $display("hsv_light_color_classifier_core: match");
    else
      $display("hsv_light_color_classifier_core: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/hlcc_pkg.sv
rtl/core/hlcc_stream_if.sv
rtl/core/hlcc_front.sv
rtl/core/hlcc_queue.sv
rtl/core/hlcc_back.sv
rtl/core/hsv_light_color_classifier_core.sv
rtl/core/hlcc_checker.sv
tb/hsv_light_color_classifier_core_test.sv
